FILE: hdl/crc8hc_pkg.sv
package crc8hc_pkg;

    // Frame limits
    localparam int unsigned MAX_DATA_BYTES = 255;
    localparam int unsigned DATA_COUNT_W   = 9;

    // CRC-8 polynomial and framing characters
    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] SEP_CHAR = 8'h3F;  // '?'
    localparam logic [7:0] END_CHAR = 8'h23;  // '#'
    localparam logic [7:0] CHAR_ZERO = 8'h30; // '0'
    localparam logic [7:0] CHAR_A    = 8'h61; // 'a'

    typedef enum logic [1:0] {
        PH_DATA   = 2'd0,
        PH_SUFFIX = 2'd1,
        PH_DONE   = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_MISMATCH = 3'd1,
        ST_NO_SEP   = 3'd2,
        ST_ORDER    = 3'd3,
        ST_TOO_LONG = 3'd4
    } status_t;

    typedef struct packed {
        logic       crc_ok;
        logic [7:0] computed_crc;
        status_t    status;
    } result_t;

    // Advance the CRC by one byte, MSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (v[7])
            begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

    // Lower-case hex character for one nibble
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] c;
        if (n < 4'd10)
        begin
            c = CHAR_ZERO + {4'd0, n};
        end
        else
        begin
            c = CHAR_A + {4'd0, n} - 8'd10;
        end
        return c;
    endfunction

endpackage

FILE: hdl/crc8hc_frame.sv
module crc8hc_frame (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [7:0]          byte_in,
    input  logic                last_in,
    output crc8hc_pkg::result_t result
);

    logic [7:0]                            crc_reg, crc_next;
    crc8hc_pkg::phase_t                    phase_reg, phase_next;
    logic [crc8hc_pkg::DATA_COUNT_W-1:0]   data_count_reg, data_count_next;
    logic [1:0]                            suffix_count_reg, suffix_count_next;
    logic [7:0]                            suffix_hi_reg, suffix_hi_next;
    logic [7:0]                            suffix_lo_reg, suffix_lo_next;
    logic                                  order_error_reg, order_error_next;
    logic                                  text_match;

    // Work out the frame state after this byte
    always_comb
    begin
        crc_next          = crc_reg;
        phase_next        = phase_reg;
        data_count_next   = data_count_reg;
        suffix_count_next = suffix_count_reg;
        suffix_hi_next    = suffix_hi_reg;
        suffix_lo_next    = suffix_lo_reg;
        order_error_next  = order_error_reg;
        case (phase_reg)
            crc8hc_pkg::PH_DATA:
            begin
                if (byte_in == crc8hc_pkg::SEP_CHAR)
                begin
                    phase_next = crc8hc_pkg::PH_SUFFIX;
                end
                else
                begin
                    if (byte_in == crc8hc_pkg::END_CHAR)
                    begin
                        order_error_next = 1'b1;
                    end
                    crc_next = crc8hc_pkg::crc8_byte(crc_reg, byte_in);
                    if (data_count_reg <= crc8hc_pkg::DATA_COUNT_W'(crc8hc_pkg::MAX_DATA_BYTES))
                    begin
                        data_count_next = data_count_reg + 1'b1;
                    end
                end
            end
            crc8hc_pkg::PH_SUFFIX:
            begin
                if (byte_in == crc8hc_pkg::END_CHAR)
                begin
                    phase_next = crc8hc_pkg::PH_DONE;
                end
                else
                begin
                    if (suffix_count_reg == 2'd0)
                    begin
                        suffix_hi_next = byte_in;
                    end
                    else if (suffix_count_reg == 2'd1)
                    begin
                        suffix_lo_next = byte_in;
                    end
                    if (suffix_count_reg != 2'd3)
                    begin
                        suffix_count_next = suffix_count_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                // ignore the tail after the closing '#'
            end
        endcase
    end

    // Judge the frame from the updated state
    assign text_match = (suffix_count_next == 2'd2)
                     && (suffix_hi_next == crc8hc_pkg::hex_char(crc_next[7:4]))
                     && (suffix_lo_next == crc8hc_pkg::hex_char(crc_next[3:0]));

    always_comb
    begin
        if (phase_next == crc8hc_pkg::PH_DATA)
        begin
            result.status = crc8hc_pkg::ST_NO_SEP;
        end
        else if (order_error_next)
        begin
            result.status = crc8hc_pkg::ST_ORDER;
        end
        else if (data_count_next > crc8hc_pkg::DATA_COUNT_W'(crc8hc_pkg::MAX_DATA_BYTES))
        begin
            result.status = crc8hc_pkg::ST_TOO_LONG;
        end
        else if (text_match)
        begin
            result.status = crc8hc_pkg::ST_OK;
        end
        else
        begin
            result.status = crc8hc_pkg::ST_MISMATCH;
        end
        result.crc_ok       = (result.status == crc8hc_pkg::ST_OK);
        result.computed_crc = crc_next;
    end

    // Hold the frame state; clear it after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg          <= '0;
            phase_reg        <= crc8hc_pkg::PH_DATA;
            data_count_reg   <= '0;
            suffix_count_reg <= '0;
            suffix_hi_reg    <= '0;
            suffix_lo_reg    <= '0;
            order_error_reg  <= 1'b0;
        end
        else if (take)
        begin
            if (last_in)
            begin
                crc_reg          <= '0;
                phase_reg        <= crc8hc_pkg::PH_DATA;
                data_count_reg   <= '0;
                suffix_count_reg <= '0;
                suffix_hi_reg    <= '0;
                suffix_lo_reg    <= '0;
                order_error_reg  <= 1'b0;
            end
            else
            begin
                crc_reg          <= crc_next;
                phase_reg        <= phase_next;
                data_count_reg   <= data_count_next;
                suffix_count_reg <= suffix_count_next;
                suffix_hi_reg    <= suffix_hi_next;
                suffix_lo_reg    <= suffix_lo_next;
                order_error_reg  <= order_error_next;
            end
        end
    end

endmodule

FILE: hdl/crc8hc_out.sv
module crc8hc_out (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  crc8hc_pkg::result_t result,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                crc_ok,
    output logic [7:0]          computed_crc,
    output logic [2:0]          status
);

    logic                out_valid_reg;
    crc8hc_pkg::result_t result_reg;

    // Free when empty or being drained this cycle
    assign room = !out_valid_reg || out_ready;

    // Track result occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (room)
        begin
            out_valid_reg <= load;
        end
    end

    // Capture the result item
    always_ff @(posedge clk)
    begin
        if (load && room)
        begin
            result_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign crc_ok       = result_reg.crc_ok;
    assign computed_crc = result_reg.computed_crc;
    assign status       = result_reg.status;

endmodule

FILE: hdl/crc8_hex_suffix_checker.sv
// CRC-8 text frame checker. Feed one character per item with frame_last on the
// final byte; the block keeps a CRC-8 (poly 0x07, init 0, no reflection, no
// final XOR) over the bytes before the first '?', captures the text after it
// up to '#' or the frame end, and on the last byte emits one result: crc_ok,
// computed_crc and status (0 ok, 1 mismatch, 2 no '?', 3 '#' before '?',
// 4 more than 255 data bytes). Throughput is one item per cycle while no last
// byte is held back by a waiting result; each byte is registered in the input
// register, and the result of a frame is written to the output register at the
// edge where its last byte leaves the input register. A result waiting for
// out_ready holds back only the last byte of the following frame.
// The CRC byte update and character compares are combinational logic.
module crc8_hex_suffix_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       frame_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       crc_ok,
    output logic [7:0] computed_crc,
    output logic [2:0] status
);

    logic                stage_valid_reg;
    logic [7:0]          stage_byte_reg;
    logic                stage_last_reg;
    logic                stage_take;
    logic                room;
    crc8hc_pkg::result_t result;

    // Advance the staged item unless its result has nowhere to go
    assign stage_take = stage_valid_reg && (!stage_last_reg || room);
    assign in_ready   = !stage_valid_reg || stage_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    // Capture the incoming item
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_byte_reg <= data_byte;
            stage_last_reg <= frame_last;
        end
    end

    crc8hc_frame u_frame (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (stage_take),
        .byte_in (stage_byte_reg),
        .last_in (stage_last_reg),
        .result  (result)
    );

    crc8hc_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (stage_take && stage_last_reg),
        .result       (result),
        .room         (room),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .crc_ok       (crc_ok),
        .computed_crc (computed_crc),
        .status       (status)
    );

endmodule

FILE: hdl/crc8hc_sva.sv
module crc8hc_sva (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] data_byte,
    input logic       frame_last,
    input logic       out_valid,
    input logic       out_ready,
    input logic       crc_ok,
    input logic [7:0] computed_crc,
    input logic [2:0] status
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(computed_crc) && $stable(status))
    else $error("stalled result changed");

    // crc_ok agrees with status
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (crc_ok == (status == crc8hc_pkg::ST_OK)))
    else $error("crc_ok disagrees with status");

    // Status is a known code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == crc8hc_pkg::ST_OK || status == crc8hc_pkg::ST_MISMATCH
                    || status == crc8hc_pkg::ST_NO_SEP || status == crc8hc_pkg::ST_ORDER
                    || status == crc8hc_pkg::ST_TOO_LONG))
    else $error("status code out of range");

    // With the output empty the input never stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind crc8_hex_suffix_checker crc8hc_sva u_sva (.*);
